FILE: hw/rtl/afr_pkg.sv
package afr_pkg;

    localparam int RX_W      = 8;
    localparam int ADDR_W    = 7;
    localparam int SUM_W     = 7;
    localparam int WORD_W    = 16;
    localparam int TX_W      = 7;
    localparam int CNT_W     = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // frame layout: address, three data bytes, checksum
    localparam logic [CNT_W-1:0] CNT_ADDR   = 3'd0;
    localparam logic [CNT_W-1:0] CNT_DATA0  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_DATA1  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_DATA2  = 3'd3;
    localparam logic [CNT_W-1:0] FRAME_LEN  = 3'd5;

    localparam logic [SUM_W-1:0]  SUM_SEED      = 7'h7f;  // 0xFF modulo 128
    localparam logic [ADDR_W-1:0] ADDR_RESET    = 7'd42;
    localparam logic [TX_W-1:0]   RESP_DATA     = 7'd0;
    localparam logic [TX_W-1:0]   RESP_CHECKSUM = 7'd1;   // -(0xFF + 0) modulo 128

    // beat codes of the two-beat response
    localparam logic BEAT_DATA = 1'b0;
    localparam logic BEAT_SUM  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } afr_frame_t;

    typedef struct packed {
        logic empty;
        logic full;
    } afr_qstat_t;

endpackage

FILE: hw/rtl/afr_front.sv
module afr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [afr_pkg::ADDR_W-1:0]   cfg_wr_data,
    input  logic                         rx_accept,
    input  logic [afr_pkg::RX_W-1:0]     rx_byte,
    output afr_pkg::afr_frame_t          frame_out
);
    import afr_pkg::*;

    logic [ADDR_W-1:0] dev_addr_reg;
    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [SUM_W-1:0]  running_sum_reg, running_sum_next;
    logic [WORD_W-1:0] data_word_reg, data_word_next;

    logic              is_addr, own_addr, open;
    logic [CNT_W-1:0]  cnt_base, cnt_inc;
    logic [SUM_W-1:0]  sum_new;
    logic [WORD_W-1:0] word_new;

    always_comb begin
        is_addr  = rx_byte[RX_W-1];
        own_addr = (rx_byte == {1'b1, dev_addr_reg});
        open     = is_addr ? own_addr : in_frame_reg;
        cnt_base = (is_addr && own_addr) ? CNT_ADDR : byte_count_reg;
        cnt_inc  = cnt_base + 3'd1;

        sum_new  = running_sum_reg + rx_byte[SUM_W-1:0];
        word_new = data_word_reg;
        unique case (cnt_base)
            CNT_ADDR: begin
                sum_new  = SUM_SEED + rx_byte[SUM_W-1:0];
                word_new = '0;
            end
            CNT_DATA0: word_new = {{(WORD_W-RX_W){1'b0}}, rx_byte};
            CNT_DATA1: word_new = data_word_reg | (WORD_W'(rx_byte) << 7);
            CNT_DATA2: word_new = data_word_reg | (WORD_W'(rx_byte) << 14);
            default:   word_new = data_word_reg;
        endcase

        in_frame_next    = in_frame_reg;
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        data_word_next   = data_word_reg;
        frame_out.valid  = 1'b0;
        frame_out.word   = word_new;

        if (rx_accept) begin
            in_frame_next = open;
            if (open) begin
                running_sum_next = sum_new;
                data_word_next   = word_new;
                if (cnt_inc == FRAME_LEN) begin
                    // close the frame; hand it on only with a good checksum
                    in_frame_next   = 1'b0;
                    byte_count_next = CNT_ADDR;
                    frame_out.valid = (sum_new == '0);
                end else begin
                    byte_count_next = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg    <= ADDR_RESET;
            in_frame_reg    <= 1'b0;
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            data_word_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                dev_addr_reg <= cfg_wr_data;
            end
            in_frame_reg    <= in_frame_next;
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            data_word_reg   <= data_word_next;
        end
    end

endmodule

FILE: hw/rtl/afr_queue.sv
module afr_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  afr_pkg::afr_frame_t           push,
    input  logic                          pop,
    output logic [afr_pkg::WORD_W-1:0]    head_word,
    output afr_pkg::afr_qstat_t           stat
);
    import afr_pkg::*;

    logic [WORD_W-1:0] mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_word  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/afr_back.sv
module afr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  afr_pkg::afr_qstat_t            qstat,
    input  logic [afr_pkg::WORD_W-1:0]     head_word,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [afr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import afr_pkg::*;

    logic beat_reg;
    logic fire;

    assign m_tvalid = !qstat.empty;
    assign m_tlast  = (beat_reg == BEAT_SUM);
    assign fire     = m_tvalid && m_tready;
    assign pop      = fire && m_tlast;

    always_comb begin
        m_tdata = '0;
        case (beat_reg)
            BEAT_DATA: m_tdata = {1'b0, RESP_DATA, head_word};
            default:   m_tdata = {1'b0, RESP_CHECKSUM, {WORD_W{1'b0}}};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= BEAT_DATA;
        end else if (fire) begin
            beat_reg <= (beat_reg == BEAT_DATA) ? BEAT_SUM : BEAT_DATA;
        end
    end

endmodule

FILE: hw/rtl/addressed_frame_receiver_top.sv
// Flow: a good frame enters the frame queue when its last byte is accepted; its data
//   beat is offered from the queue head, the second beat once the first is taken.
// Throughput: one byte per cycle on s_; the front stalls only while the two-entry
//   frame queue is full. Each good frame yields two beats on m_.
// Reset: aresetn, synchronous, active low; clears frame state, queue and beat phase,
//   and sets the device address to 42.
module addressed_frame_receiver_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: address this unit answers to
    input  logic                               cfg_wr_en,
    input  logic [afr_pkg::ADDR_W-1:0]         cfg_wr_data,
    // received byte stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [afr_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [afr_pkg::M_TDATA_W-1:0]      m_tdata,   // [15:0] out_word, [22:16] tx_byte, [23] zero
    output logic                               m_tlast    // tx_last
);
    import afr_pkg::*;

    afr_frame_t        frame;
    afr_qstat_t        qstat;
    logic [WORD_W-1:0] head_word;
    logic              pop;
    logic              rx_accept;

    // Accept a byte whenever the queue has room for a frame it might complete.
    assign s_tready  = !qstat.full;
    assign rx_accept = s_tvalid && s_tready;

    // Front: parse the byte stream, check the running sum, emit finished frames.
    afr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_accept   (rx_accept),
        .rx_byte     (s_tdata[RX_W-1:0]),
        .frame_out   (frame)
    );

    // Queue: hold good frames so that a stalled sink does not stop the parser at once.
    afr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (frame),
        .pop       (pop),
        .head_word (head_word),
        .stat      (qstat)
    );

    // Back: turn each queued frame into the data beat and the checksum beat.
    afr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .head_word (head_word),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef ASSERT_OFF
    // A finished frame never meets a full queue.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        frame.valid |-> !qstat.full)
        else $error("frame completed while queue full");

    // A taken data beat is followed by the checksum beat of the same frame.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("data beat not followed by checksum beat");

    // The last beat carries the response checksum and a zero word.
    a_last_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == {1'b0, RESP_CHECKSUM, {WORD_W{1'b0}}}))
        else $error("bad checksum beat");
`endif

endmodule

FILE: sim/addressed_frame_receiver_top_tb.sv
module addressed_frame_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afr_pkg::*;

    localparam int ITEMS_PER_PHASE = 230;
    localparam int DRAIN_GAP       = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 500;
    localparam int LIMIT_CYCLES    = 200000;

    // Track the frame state of the receiver and hold the response beats still owed.
    class frame_response_tracker;
        typedef struct packed {
            bit [WORD_W-1:0] word;
            bit [TX_W-1:0]   tx;
            bit              last;
        } response_beat_t;

        bit [ADDR_W-1:0] dev_addr;
        bit              collecting;
        bit [CNT_W-1:0]  count;
        bit [SUM_W-1:0]  sum;
        bit [WORD_W-1:0] word;
        response_beat_t  responses_due[$];
        int              errors;

        function new();
            dev_addr   = ADDR_RESET;
            collecting = 1'b0;
            count      = '0;
            sum        = '0;
            word       = '0;
            errors     = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Advance the frame state by one accepted byte; return 0 if the byte was ignored.
        function bit note_rx_byte(input bit [RX_W-1:0] b);
            response_beat_t beat;
            if (b[7]) begin
                if (b[6:0] == dev_addr) begin
                    collecting = 1'b1;
                    count      = '0;
                end else begin
                    collecting = 1'b0;
                end
            end
            if (!collecting)
                return b[7];
            case (count)
                CNT_ADDR: begin
                    sum  = SUM_SEED + b[6:0];
                    word = '0;
                end
                CNT_DATA0: begin
                    sum  = sum + b[6:0];
                    word = WORD_W'(b);
                end
                CNT_DATA1: begin
                    sum  = sum + b[6:0];
                    word = word | (WORD_W'(b) << 7);
                end
                CNT_DATA2: begin
                    sum  = sum + b[6:0];
                    word = word | (WORD_W'(b) << 14);
                end
                default: begin
                    sum = sum + b[6:0];
                end
            endcase
            count = count + 1'b1;
            if (count < FRAME_LEN)
                return 1'b1;
            collecting = 1'b0;
            count      = '0;
            if (sum == '0) begin
                beat.word = word;
                beat.tx   = RESP_DATA;
                beat.last = 1'b0;
                responses_due.push_back(beat);
                beat.word = '0;
                beat.tx   = TX_W'(0) - (SUM_SEED + RESP_DATA);
                beat.last = 1'b1;
                responses_due.push_back(beat);
            end
            return 1'b1;
        endfunction

        task check_response_beat(input bit [WORD_W-1:0] word_got, input bit [TX_W-1:0] tx_got,
                                 input bit last_got);
            response_beat_t want;
            if (responses_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat word=%h tx=%h last=%b",
                                          word_got, tx_got, last_got));
                return;
            end
            want = responses_due.pop_front();
            if (word_got != want.word)
                report_mismatch($sformatf("out_word got %h want %h", word_got, want.word));
            if (tx_got != want.tx)
                report_mismatch($sformatf("tx_byte got %h want %h", tx_got, want.tx));
            if (last_got != want.last)
                report_mismatch($sformatf("tx_last got %b want %b", last_got, want.last));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [ADDR_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    frame_response_tracker tracker;
    int unsigned           cycle_count;
    int unsigned           accepted_bytes;
    int unsigned           useful_bytes;
    int                    burst_left;
    bit [ADDR_W-1:0]       phase_addr [5];

    addressed_frame_receiver_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Count cycles and give up on a hang.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every result beat taken at this edge against the oldest one still owed.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_response_beat(m_tdata[15:0], m_tdata[22:16], m_tlast);
    end

    // Receiver: stall on a pattern of its own, in stretches of changing character.
    // Once, well into the run, hold off for a long stretch so that the response queue
    // fills and the block has to stall its byte input.
    initial begin
        int       mode;
        int       stretch_left;
        bit [7:0] stall_mask;
        bit       held_off;
        bit       ready;
        stretch_left = 0;
        held_off     = 1'b0;
        stall_mask   = 8'hff;
        mode         = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_off && accepted_bytes >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            if (stretch_left == 0) begin
                mode         = $urandom_range(0, 3);
                stretch_left = $urandom_range(5, 60);
                stall_mask   = 8'($urandom_range(1, 255));
            end
            stretch_left--;
            case (mode)
                0:       ready = 1'b1;                         // no stall at all
                1:       ready = 1'($urandom_range(0, 1));
                2:       ready = ($urandom_range(0, 3) != 0);
                default: begin                                 // rotating mask
                    ready      = stall_mask[0];
                    stall_mask = {stall_mask[0], stall_mask[7:1]};
                end
            endcase
            m_tready <= ready;
        end
    end

    // Offer one byte and wait for its handshake. The sender works in bursts; at the
    // start of a new burst drop tvalid for a random gap, sometimes none at all.
    // Call only straight after a rising edge.
    task automatic send_byte(input bit [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        accepted_bytes++;
        if (tracker.note_rx_byte(b))
            useful_bytes++;
    endtask

    // Checksum byte that makes 0xFF plus the whole frame vanish modulo 128.
    function automatic bit [7:0] frame_checksum(input bit [7:0] a, input bit [7:0] d0,
                                                input bit [7:0] d1, input bit [7:0] d2);
        bit [6:0] part;
        part = 7'h7f + a[6:0] + d0[6:0] + d1[6:0] + d2[6:0];
        return {1'b0, 7'(7'd0 - part)};
    endfunction

    task automatic send_frame(input bit [7:0] a, input bit [7:0] d0, input bit [7:0] d1,
                              input bit [7:0] d2, input bit [7:0] chk);
        send_byte(a);
        send_byte(d0);
        send_byte(d1);
        send_byte(d2);
        send_byte(chk);
    endtask

    task automatic send_good_frame(input bit [7:0] d0, input bit [7:0] d1, input bit [7:0] d2);
        bit [7:0] a;
        a = {1'b1, tracker.dev_addr};
        send_frame(a, d0, d1, d2, frame_checksum(a, d0, d1, d2));
    endtask

    task automatic run_directed();
        bit [7:0] own;
        own = {1'b1, tracker.dev_addr};
        // stray data bytes with no frame open: ignored
        send_byte(8'h00);
        send_byte(8'h7f);
        // good frames at both data extremes
        send_good_frame(8'h00, 8'h00, 8'h00);
        send_good_frame(8'h7f, 8'h7f, 8'h7f);
        // bad checksum: dropped silently
        send_frame(own, 8'h15, 8'h2a, 8'h55, frame_checksum(own, 8'h15, 8'h2a, 8'h55) ^ 8'h01);
        // own address inside a frame restarts it
        send_byte(own);
        send_byte(8'h11);
        send_good_frame(8'h01, 8'h02, 8'h03);
        // another address aborts the frame; what follows is ignored
        send_byte(own);
        send_byte(8'h12);
        send_byte(8'hff);
        send_byte(8'h33);
    endtask

    // Mostly well-formed frames with random content; the rest is broken frames,
    // foreign addresses and line noise.
    task automatic run_random(input int quota);
        int unsigned target;
        int          pick;
        int          n;
        bit [7:0]    own;
        bit [7:0]    d0;
        bit [7:0]    d1;
        bit [7:0]    d2;
        target = useful_bytes + quota;
        own    = {1'b1, tracker.dev_addr};
        while (useful_bytes < target) begin
            pick = $urandom_range(0, 99);
            d0   = 8'($urandom_range(0, 127));
            d1   = 8'($urandom_range(0, 127));
            d2   = 8'($urandom_range(0, 127));
            if (pick < 65) begin
                send_good_frame(d0, d1, d2);
            end else if (pick < 75) begin
                send_frame(own, d0, d1, d2,
                           frame_checksum(own, d0, d1, d2) ^ 8'($urandom_range(1, 127)));
            end else if (pick < 82) begin
                // truncated frame
                send_byte(own);
                n = $urandom_range(0, 3);
                repeat (n) send_byte(8'($urandom_range(0, 127)));
            end else if (pick < 88) begin
                // raw bytes in the frame may restart or abort it
                send_frame(own, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)));
            end else if (pick < 94) begin
                send_byte(8'($urandom_range(128, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Drop tvalid and wait until every owed beat has come, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.responses_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_address(input bit [ADDR_W-1:0] a);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.dev_addr = a;
    endtask

    initial begin
        tracker        = new();
        cycle_count    = 0;
        accepted_bytes = 0;
        useful_bytes   = 0;
        burst_left     = 0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        // address extremes first, then a few random ones
        phase_addr[0] = 7'd0;
        phase_addr[1] = 7'd127;
        for (int i = 2; i < 5; i++)
            phase_addr[i] = 7'($urandom_range(1, 126));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first phase runs on the reset address
        run_directed();
        run_random(ITEMS_PER_PHASE);
        for (int i = 0; i < 5; i++) begin
            drain();
            write_address(phase_addr[i]);
            run_random(ITEMS_PER_PHASE);
        end
        drain();

        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
